// ----- src/mcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, constants and the class encoder for the monotonic classify
// and sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;

    typedef logic signed [31:0] t_value;

    typedef enum logic [2:0] {
        CLASS_SINC     = 3'd0,
        CLASS_SDEC     = 3'd1,
        CLASS_NDEC     = 3'd2,
        CLASS_NINC     = 3'd3,
        CLASS_UNSORTED = 3'd4
    } t_class;

    localparam int FLAG_SINC = 0;
    localparam int FLAG_SDEC = 1;
    localparam int FLAG_NDEC = 2;
    localparam int FLAG_NINC = 3;

    typedef enum logic [1:0] {
        ST_LOAD   = 2'd0,
        ST_SETTLE = 2'd1,
        ST_EMIT   = 2'd2
    } t_state;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_in_word;

    typedef struct packed {
        logic [2:0] class_code;
        t_value     sorted_value;
        logic       has_value;
        logic       end_of_run;
        logic       overflow;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    function automatic t_class classify(input logic [3:0] flags);
        t_class c;
        priority if (flags[FLAG_SINC]) c = CLASS_SINC;
        else if (flags[FLAG_SDEC])     c = CLASS_SDEC;
        else if (flags[FLAG_NDEC])     c = CLASS_NDEC;
        else if (flags[FLAG_NINC])     c = CLASS_NINC;
        else                           c = CLASS_UNSORTED;
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/mcs_stream_if.sv -----
// ----------------------------------------------------------------------------
// mcs_stream_if
// Valid/ready stream channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mcs_cell.sv -----
// ----------------------------------------------------------------------------
// mcs_cell
// One sorting cell: keeps the smaller of its stored and incoming values,
// hands the larger one to the next cell, and shifts toward the head on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_cell
    import mcs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_in_valid,
    input  wire t_value    i_in_value,
    input  wire logic      i_next_full,
    input  wire t_value    i_next_value,
    output logic           o_full,
    output t_value         o_value,
    output logic           o_pass_valid,
    output t_value         o_pass_value
);

    logic   r_full, n_full;
    t_value r_value, n_value;
    logic   r_pass_valid, n_pass_valid;
    t_value r_pass_value, n_pass_value;

    always_comb begin
        n_full       = r_full;
        n_value      = r_value;
        n_pass_valid = 1'b0;
        n_pass_value = r_pass_value;
        priority if (i_ctl.clear) begin
            n_full = 1'b0;
        end else if (i_ctl.shift) begin
            n_full  = i_next_full;
            n_value = i_next_value;
        end else if (i_in_valid) begin
            if (!r_full) begin
                n_full  = 1'b1;
                n_value = i_in_value;
            end else if (i_in_value < r_value) begin
                n_value      = i_in_value;
                n_pass_valid = 1'b1;
                n_pass_value = r_value;
            end else begin
                n_pass_valid = 1'b1;
                n_pass_value = i_in_value;
            end
        end else begin
            n_pass_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= 1'b0;
            r_pass_valid <= 1'b0;
        end else begin
            r_full       <= n_full;
            r_pass_valid <= n_pass_valid;
        end
        r_value      <= n_value;
        r_pass_value <= n_pass_value;
    end

    assign o_full       = r_full;
    assign o_value      = r_value;
    assign o_pass_valid = r_pass_valid;
    assign o_pass_value = r_pass_value;

endmodule

`default_nettype wire

// ----- src/monotonic_classify_and_sort_top.sv -----
// ----------------------------------------------------------------------------
// monotonic_classify_and_sort_top
// Classifies a run of Q16.16 values by order and, for an unsorted run,
// returns its elements in ascending order through a chain of sorting cells.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word        Fields
//  i_in      in   t_in_word   value, last
//  o_out     out  t_out_word  class_code, sorted_value, has_value, end_of_run,
//                             overflow
//
//  Elements are taken one per cycle while a run loads and ripple down the
//  chain one cell per cycle; after the last one the chain settles before the
//  result is given. A sorted run then yields one result word, and an unsorted
//  run drains one element per cycle from the head cell while o_out accepts
//  words. Reset is synchronous and empties all cells; i_in is held off until
//  the run's final word is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module monotonic_classify_and_sort_top
    import mcs_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mcs_stream_if.sink   i_in,
    mcs_stream_if.source o_out
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    t_value    r_prev, n_prev;
    logic [3:0] r_flags, n_flags;
    logic      r_ovf_seen, n_ovf_seen;
    t_class    r_class, n_class;
    logic      r_ovf, n_ovf;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    t_cell_ctl ctl;
    logic      in_acc, in_store, out_take, busy;
    logic      emit_load;

    logic [MAX_ELEMENTS-1:0] cell_full;
    logic [MAX_ELEMENTS-1:0] pass_valid;
    t_value cell_value [MAX_ELEMENTS];
    t_value pass_value [MAX_ELEMENTS];

    assign i_in.ready = (r_state == ST_LOAD);
    assign in_acc   = i_in.valid && i_in.ready;
    assign in_store = in_acc && (r_count < CW'(MAX_ELEMENTS));
    assign out_take = !r_out_valid || o_out.ready;
    assign busy     = |pass_valid;

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic   in_v, nx_f;
        t_value in_d, nx_d;
        if (g == 0) begin : g_head
            assign in_v = in_store;
            assign in_d = i_in.data.value;
        end else begin : g_body
            assign in_v = pass_valid[g-1];
            assign in_d = pass_value[g-1];
        end
        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign nx_f = 1'b0;
            assign nx_d = '0;
        end else begin : g_link
            assign nx_f = cell_full[g+1];
            assign nx_d = cell_value[g+1];
        end
        mcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_in_valid   (in_v),
            .i_in_value   (in_d),
            .i_next_full  (nx_f),
            .i_next_value (nx_d),
            .o_full       (cell_full[g]),
            .o_value      (cell_value[g]),
            .o_pass_valid (pass_valid[g]),
            .o_pass_value (pass_value[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_prev      = r_prev;
        n_flags     = r_flags;
        n_ovf_seen  = r_ovf_seen;
        n_class     = r_class;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        ctl         = '0;
        emit_load   = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                if (in_store) begin
                    if (r_count != '0) begin
                        if (!(r_prev < i_in.data.value))  n_flags[FLAG_SINC] = 1'b0;
                        if (!(r_prev > i_in.data.value))  n_flags[FLAG_SDEC] = 1'b0;
                        if (!(r_prev <= i_in.data.value)) n_flags[FLAG_NDEC] = 1'b0;
                        if (!(r_prev >= i_in.data.value)) n_flags[FLAG_NINC] = 1'b0;
                    end
                    n_prev  = i_in.data.value;
                    n_count = r_count + CW'(1);
                end else if (in_acc) begin
                    n_ovf_seen = 1'b1;
                end
                if (in_acc && i_in.data.last) begin
                    n_class    = classify(n_flags);
                    n_ovf      = n_ovf_seen;
                    n_left     = n_count;
                    n_count    = '0;
                    n_flags    = '1;
                    n_ovf_seen = 1'b0;
                    n_state    = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (!busy && out_take) begin
                    if (r_class != CLASS_UNSORTED) begin
                        n_out_valid        = 1'b1;
                        n_out.class_code   = r_class;
                        n_out.sorted_value = '0;
                        n_out.has_value    = 1'b0;
                        n_out.end_of_run   = 1'b1;
                        n_out.overflow     = r_ovf;
                        ctl.clear          = 1'b1;
                        n_state            = ST_LOAD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_take) begin
                    emit_load          = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out.class_code   = CLASS_UNSORTED;
                    n_out.sorted_value = cell_value[0];
                    n_out.has_value    = 1'b1;
                    n_out.end_of_run   = (r_left == CW'(1));
                    n_out.overflow     = r_ovf;
                    ctl.shift          = 1'b1;
                    n_left             = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        ctl.clear = 1'b1;
                        n_state   = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_flags     <= '1;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_ovf_seen  <= n_ovf_seen;
            r_out_valid <= n_out_valid;
        end
        r_left  <= n_left;
        r_prev  <= n_prev;
        r_class <= n_class;
        r_ovf   <= n_ovf;
        r_out   <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !busy)
        else $error("drain started while cells still in flight");
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("drain with no elements left");
    a_emit_head_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |-> cell_full[0])
        else $error("drained an empty head cell");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");
`endif

endmodule

`default_nettype wire
